// File: rtl/core/ptet_pkg.sv
// Package for the periodic timer event table: operation and result codes,
// field widths and the layout of one table entry. No dependencies.
`timescale 1ns / 1ps

package ptet_pkg;

  // Field widths.
  localparam int unsigned OpW     = 2;
  localparam int unsigned KindW   = 3;
  localparam int unsigned IdW     = 16;
  localparam int unsigned TicksW  = 32;

  // Operation codes carried on the input tuser.
  localparam logic [OpW-1:0] OpTick   = 2'd0;
  localparam logic [OpW-1:0] OpStart  = 2'd1;
  localparam logic [OpW-1:0] OpCancel = 2'd2;
  localparam logic [OpW-1:0] OpQuery  = 2'd3;

  // Result kinds carried on the output tuser.
  localparam logic [KindW-1:0] KindFired     = 3'd0;
  localparam logic [KindW-1:0] KindStarted   = 3'd1;
  localparam logic [KindW-1:0] KindCancelled = 3'd2;
  localparam logic [KindW-1:0] KindRemaining = 3'd3;
  localparam logic [KindW-1:0] KindFull      = 3'd4;
  localparam logic [KindW-1:0] KindNotFound  = 3'd5;

  // One table entry as it is held in the entry memory.
  typedef struct packed {
    logic [IdW-1:0]    id;
    logic [TicksW-1:0] remaining;
    logic [TicksW-1:0] reload;
  } entry_t;

endpackage

// File: rtl/core/periodic_timer_event_table_unit.sv
// Periodic timer event table: entry memory, walk sequencer and result register.
// Depends on ptet_pkg for codes, widths and the entry layout.
`timescale 1ns / 1ps

// A start item is handled in the op state; a tick item walks the table, one entry per
// cycle through the single-port-read entry memory, and ends with no result on an empty
// table; cancel and query do a linear search. A full result register stalls the walk.
// No new input item is taken until the current one is done.
// Reset clears the count, the next id, the sequencer and the result valid flag;
// the entry memory is not cleared, as only written slots are ever read.
module periodic_timer_event_table_unit #(
  parameter int unsigned MAX_TIMERS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // [31:0] period_ticks, [47:32] target_id
  input  logic [1:0]  s_axis_tuser,   // [1:0] op
  // Result stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [15:0] timer_id, [47:16] remaining
  output logic [2:0]  m_axis_tuser,   // [2:0] kind
  output logic        m_axis_tlast    // last
);

  localparam int unsigned IdxW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
  localparam int unsigned CntW = $clog2(MAX_TIMERS + 1);

  // Sequencer states.
  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StOp     = 3'd1;
  localparam logic [2:0] StTick   = 3'd2;
  localparam logic [2:0] StTickEnd = 3'd3;
  localparam logic [2:0] StSearch = 3'd4;
  localparam logic [2:0] StCancel = 3'd5;

  logic [2:0] state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [ptet_pkg::IdW-1:0] next_id_q, next_id_d;
  logic [IdxW-1:0] idx_q, idx_d;

  // Latched input item.
  logic [ptet_pkg::OpW-1:0]    op_q;
  logic [ptet_pkg::TicksW-1:0] period_q;
  logic [ptet_pkg::IdW-1:0]    target_q;

  // Held firing of the tick walk, sent once the next firing or the end is known.
  logic                     pend_valid_q, pend_valid_d;
  logic [ptet_pkg::IdW-1:0] pend_id_q, pend_id_d;

  // Result register.
  logic                        out_valid_q;
  logic [ptet_pkg::KindW-1:0]  out_kind_q;
  logic [ptet_pkg::IdW-1:0]    out_id_q;
  logic [ptet_pkg::TicksW-1:0] out_rem_q;
  logic                        out_last_q;

  logic                        emit;
  logic [ptet_pkg::KindW-1:0]  emit_kind;
  logic [ptet_pkg::IdW-1:0]    emit_id;
  logic [ptet_pkg::TicksW-1:0] emit_rem;
  logic                        emit_last;
  logic                        out_free;

  // Entry memory with one registered read port and one write port.
  ptet_pkg::entry_t mem_q [MAX_TIMERS];
  ptet_pkg::entry_t rd_q;
  logic             re;
  logic [IdxW-1:0]  raddr;
  logic             we;
  logic [IdxW-1:0]  waddr;
  ptet_pkg::entry_t wdata;

  logic [CntW-1:0] count_m1;
  logic [CntW-1:0] idx_p1;
  logic            at_end;
  logic            full;
  logic            fire;
  logic            match;

  assign s_axis_tready = (state_q == StIdle);
  assign out_free      = !out_valid_q || m_axis_tready;
  assign count_m1      = count_q - CntW'(1);
  assign idx_p1        = CntW'(idx_q) + CntW'(1);
  assign at_end        = (idx_p1 == count_q);
  assign full          = (count_q >= CntW'(MAX_TIMERS));
  assign fire          = (rd_q.remaining == '0);
  assign match         = (rd_q.id == target_q);

  // Memory access: the walk writes entry idx while reading idx + 1, so the
  // read and write addresses never meet and no forwarding is needed.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (re) begin
      rd_q <= mem_q[raddr];
    end
  end

  // Sequencer.
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    next_id_d    = next_id_q;
    idx_d        = idx_q;
    pend_valid_d = pend_valid_q;
    pend_id_d    = pend_id_q;
    re           = 1'b0;
    raddr        = '0;
    we           = 1'b0;
    waddr        = idx_q;
    wdata        = rd_q;
    emit         = 1'b0;
    emit_kind    = ptet_pkg::KindFired;
    emit_id      = '0;
    emit_rem     = '0;
    emit_last    = 1'b1;

    case (state_q)
      StIdle: begin
        if (s_axis_tvalid) begin
          state_d = StOp;
        end
      end

      StOp: begin
        case (op_q)
          ptet_pkg::OpTick: begin
            if (count_q == '0) begin
              state_d = StIdle;
            end else begin
              re           = 1'b1;
              idx_d        = '0;
              pend_valid_d = 1'b0;
              state_d      = StTick;
            end
          end
          ptet_pkg::OpStart: begin
            if (out_free) begin
              emit    = 1'b1;
              state_d = StIdle;
              if (full) begin
                emit_kind = ptet_pkg::KindFull;
              end else begin
                we              = 1'b1;
                waddr           = count_q[IdxW-1:0];
                wdata.id        = next_id_q;
                wdata.remaining = period_q;
                wdata.reload    = period_q;
                count_d         = count_q + CntW'(1);
                next_id_d       = next_id_q + ptet_pkg::IdW'(1);
                emit_kind       = ptet_pkg::KindStarted;
                emit_id         = next_id_q;
              end
            end
          end
          default: begin
            if (count_q == '0) begin
              if (out_free) begin
                emit      = 1'b1;
                emit_kind = ptet_pkg::KindNotFound;
                emit_id   = target_q;
                state_d   = StIdle;
              end
            end else begin
              re      = 1'b1;
              idx_d   = '0;
              state_d = StSearch;
            end
          end
        endcase
      end

      // One entry per cycle; a firing that must push a held one waits for room.
      StTick: begin
        if (!(fire && pend_valid_q && !out_free)) begin
          we = 1'b1;
          if (fire) begin
            wdata.remaining = rd_q.reload;
            emit            = pend_valid_q;
            emit_id         = pend_id_q;
            emit_last       = 1'b0;
            pend_valid_d    = 1'b1;
            pend_id_d       = rd_q.id;
          end else begin
            wdata.remaining = rd_q.remaining - ptet_pkg::TicksW'(1);
          end
          if (at_end) begin
            state_d = StTickEnd;
          end else begin
            idx_d = idx_p1[IdxW-1:0];
            re    = 1'b1;
            raddr = idx_p1[IdxW-1:0];
          end
        end
      end

      // The held firing is the final result of the tick.
      StTickEnd: begin
        if (!pend_valid_q) begin
          state_d = StIdle;
        end else if (out_free) begin
          emit         = 1'b1;
          emit_id      = pend_id_q;
          pend_valid_d = 1'b0;
          state_d      = StIdle;
        end
      end

      // Linear search for the lowest slot holding the target id.
      StSearch: begin
        if (match) begin
          if (op_q == ptet_pkg::OpQuery) begin
            if (out_free) begin
              emit      = 1'b1;
              emit_kind = ptet_pkg::KindRemaining;
              emit_id   = target_q;
              emit_rem  = rd_q.remaining;
              state_d   = StIdle;
            end
          end else begin
            re      = 1'b1;
            raddr   = count_m1[IdxW-1:0];
            state_d = StCancel;
          end
        end else if (at_end) begin
          if (out_free) begin
            emit      = 1'b1;
            emit_kind = ptet_pkg::KindNotFound;
            emit_id   = target_q;
            state_d   = StIdle;
          end
        end else begin
          idx_d = idx_p1[IdxW-1:0];
          re    = 1'b1;
          raddr = idx_p1[IdxW-1:0];
        end
      end

      // The last entry moves into the cancelled slot.
      StCancel: begin
        if (out_free) begin
          we        = 1'b1;
          count_d   = count_m1;
          emit      = 1'b1;
          emit_kind = ptet_pkg::KindCancelled;
          emit_id   = target_q;
          state_d   = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      count_q      <= '0;
      next_id_q    <= '0;
      idx_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      next_id_q    <= next_id_d;
      idx_q        <= idx_d;
      pend_valid_q <= pend_valid_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: the input item on its transfer, results on emit.
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      op_q     <= s_axis_tuser;
      period_q <= s_axis_tdata[31:0];
      target_q <= s_axis_tdata[47:32];
    end
    pend_id_q <= pend_id_d;
    if (emit) begin
      out_kind_q <= emit_kind;
      out_id_q   <= emit_id;
      out_rem_q  <= emit_rem;
      out_last_q <= emit_last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_rem_q, out_id_q};
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;

endmodule
